### design/dts_pkg.sv
// Shared constants and stage types for the decaying temperature schedule unit.
// No dependencies; imported by decaying_temperature_schedule_unit.
package dts_pkg;

  localparam logic [63:0] E_Q2_62   = 64'hADF85458A2BB4A9A;
  localparam logic [63:0] LN2_Q0_64 = 64'hB17217F7D1CF79AC;

  localparam int LOG_FRAC    = 56;
  localparam int NORM_STAGES = 5;
  localparam int SQ_ITERS    = LOG_FRAC;
  localparam int LDIV_STAGES = LOG_FRAC / 2;
  localparam int QDIV_STAGES = 32;
  localparam int SQRT_STAGES = 16;

  // Stage at which each path delivers its value, counted from the input register.
  localparam int LOG_DEPTH = NORM_STAGES + 1 + 2 * SQ_ITERS + 2 + LDIV_STAGES;
  localparam int SQ_DEPTH  = 1 + QDIV_STAGES + SQRT_STAGES;
  localparam int LIN_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_CONST  = 2'd0,
    MODE_ISQRT  = 2'd1,
    MODE_ILOG   = 2'd2,
    MODE_LINEAR = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_SCALE = 2'd1,
    REG_SLOPE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [32:0] t;
    logic [32:0] xn;
    logic [4:0]  sh;
  } norm_t;

  typedef struct packed {
    logic [63:0]         m;
    logic [LOG_FRAC-1:0] frac;
    logic [5:0]          k;
  } log_t;

  typedef struct packed {
    logic [63:0]         p0;
    logic [63:0]         p1;
    logic [63:0]         p2;
    logic [LOG_FRAC-1:0] frac;
    logic [5:0]          k;
  } sqr_t;

  typedef struct packed {
    logic [61:0]         r;
    logic [LOG_FRAC-1:0] q;
    logic [61:0]         lnq;
  } ldiv_t;

  typedef struct packed {
    logic [63:0] nq;
    logic [32:0] rem;
    logic [32:0] d;
  } qdiv_t;

  typedef struct packed {
    logic [63:0] v;
    logic [33:0] rem;
    logic [31:0] root;
  } sqrt_t;

endpackage

### design/decaying_temperature_schedule_unit.sv
// Decaying temperature schedule unit: visit count in, Q16.16 temperature out.
// Depends on dts_pkg for constants, mode codes and pipeline stage types.
// Latency is the same in every mode; the shorter paths are delayed to match the log path.
// Throughput: one word per cycle; busy only follows rst, the pipeline never stalls.
// Depth is set by the log path: 56 squarings at two stages each plus a 2-bit/stage divider.
// The receiver cannot stall: done is a one-cycle strobe with temperature beside it.
// Reset (synchronous rst): mode 0, temp_scale 1.0, slope 0, all valid bits cleared.
module decaying_temperature_schedule_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] visit_count,
  output logic        done,
  output logic [31:0] temperature,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import dts_pkg::*;

  // Restoring divide step for c * 2^56 / ln(y): one quotient bit.
  function automatic ldiv_t ldiv_step(ldiv_t s);
    ldiv_t       o;
    logic [62:0] r2;
    o  = s;
    r2 = {s.r, 1'b0};
    if (r2 >= {1'b0, s.lnq}) begin
      o.r = 62'(r2 - {1'b0, s.lnq});
      o.q = {s.q[LOG_FRAC-2:0], 1'b1};
    end else begin
      o.r = r2[61:0];
      o.q = {s.q[LOG_FRAC-2:0], 1'b0};
    end
    return o;
  endfunction

  // Restoring divide step for c*c / (x+1); quotient shifts in behind the dividend.
  function automatic qdiv_t qdiv_step(qdiv_t s);
    qdiv_t       o;
    logic [33:0] r2;
    o  = s;
    r2 = {s.rem, s.nq[63]};
    if (r2 >= {1'b0, s.d}) begin
      o.rem = 33'(r2 - {1'b0, s.d});
      o.nq  = {s.nq[62:0], 1'b1};
    end else begin
      o.rem = r2[32:0];
      o.nq  = {s.nq[62:0], 1'b0};
    end
    return o;
  endfunction

  // Digit-by-digit square root step: consume two radicand bits, emit one root bit.
  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t       o;
    logic [35:0] acc;
    logic [35:0] trial;
    o     = s;
    acc   = {s.rem, s.v[63:62]};
    trial = {2'b00, s.root, 2'b01};
    if (acc >= trial) begin
      o.rem  = 34'(acc - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = acc[33:0];
      o.root = {s.root[30:0], 1'b0};
    end
    o.v = {s.v[61:0], 2'b00};
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers. Software must write them only while no word is in
  // flight; the block does not enforce this. Every stage reads them live, no copy.
  // ---------------------------------------------------------------------------
  mode_t       mode;
  logic [31:0] temp_scale;
  logic [47:0] slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_CONST;
      temp_scale <= 32'h0001_0000;
      slope      <= '0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:  mode       <= mode_t'(cfg_data[1:0]);
        REG_SCALE: temp_scale <= cfg_data[31:0];
        REG_SLOPE: slope      <= cfg_data;
        default:   ;  // unknown index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register and valid pipeline. Stage 0 is the input register; the
  // valid bit walks alongside the data to stage LOG_DEPTH.
  // ---------------------------------------------------------------------------
  logic        accept;
  logic [31:0] x0;
  logic        valid_pipe [0:LOG_DEPTH];

  assign busy   = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    x0 <= visit_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LOG_DEPTH; i++) valid_pipe[i] <= 1'b0;
    end else begin
      valid_pipe[0] <= accept;
      for (int i = 0; i < LOG_DEPTH; i++) valid_pipe[i+1] <= valid_pipe[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Inverse natural log path (mode 2).
  // Normalize t = x+2 so its top bit lands at bit 32; shift x along with it.
  // ---------------------------------------------------------------------------
  norm_t nrm [0:NORM_STAGES];

  assign nrm[0] = '{t: {1'b0, x0} + 33'd2, xn: {1'b0, x0}, sh: 5'd0};

  for (genvar i = 0; i < NORM_STAGES; i++) begin : g_norm
    localparam int W = 16 >> i;
    always_ff @(posedge clk) begin
      if (nrm[i].t[32 -: W] == '0) begin
        nrm[i+1].t  <= nrm[i].t << W;
        nrm[i+1].xn <= nrm[i].xn << W;
        nrm[i+1].sh <= nrm[i].sh + 5'(W);
      end else begin
        nrm[i+1] <= nrm[i];
      end
    end
  end

  // Form the mantissa m = (x + e) / 2^k in Q2.62, truncated at alignment.
  log_t       lg [0:SQ_ITERS];
  logic [5:0] log_k;

  assign log_k = 6'd32 - {1'b0, nrm[NORM_STAGES].sh};

  always_ff @(posedge clk) begin
    lg[0].m    <= {1'b0, nrm[NORM_STAGES].xn, 30'b0} + (E_Q2_62 >> log_k);
    lg[0].frac <= '0;
    lg[0].k    <= log_k;
  end

  // One log2 fraction bit per squaring: partial products, then sum and renormalize.
  sqr_t sqp [0:SQ_ITERS-1];

  for (genvar j = 0; j < SQ_ITERS; j++) begin : g_square
    logic [127:0] sq_sum;
    logic [63:0]  sq_m;

    always_ff @(posedge clk) begin
      sqp[j].p0   <= lg[j].m[31:0] * lg[j].m[31:0];
      sqp[j].p1   <= lg[j].m[31:0] * lg[j].m[63:32];
      sqp[j].p2   <= lg[j].m[63:32] * lg[j].m[63:32];
      sqp[j].frac <= lg[j].frac;
      sqp[j].k    <= lg[j].k;
    end

    assign sq_sum = {sqp[j].p2, 64'b0} + {31'b0, sqp[j].p1, 33'b0} + {64'b0, sqp[j].p0};
    assign sq_m   = sq_sum[125:62];

    always_ff @(posedge clk) begin
      lg[j+1].k <= sqp[j].k;
      if (sq_m[63]) begin
        lg[j+1].m    <= {1'b0, sq_m[63:1]};
        lg[j+1].frac <= {sqp[j].frac[LOG_FRAC-2:0], 1'b1};
      end else begin
        lg[j+1].m    <= sq_m;
        lg[j+1].frac <= {sqp[j].frac[LOG_FRAC-2:0], 1'b0};
      end
    end
  end

  // ln(y) = log2(y) * ln2, Q6.56 times Q0.64, keep the high word.
  logic [61:0]  log2_q;
  logic [63:0]  ln_p0, ln_p1, ln_p2, ln_p3;
  logic [127:0] ln_sum;
  logic [61:0]  lnq;

  assign log2_q = {lg[SQ_ITERS].k, lg[SQ_ITERS].frac};

  always_ff @(posedge clk) begin
    ln_p0 <= log2_q[31:0]  * LN2_Q0_64[31:0];
    ln_p1 <= log2_q[31:0]  * LN2_Q0_64[63:32];
    ln_p2 <= log2_q[61:32] * LN2_Q0_64[31:0];
    ln_p3 <= log2_q[61:32] * LN2_Q0_64[63:32];
  end

  assign ln_sum = {ln_p3, 64'b0} + {32'b0, ln_p1, 32'b0} + {32'b0, ln_p2, 32'b0}
                + {64'b0, ln_p0};

  always_ff @(posedge clk) begin
    lnq <= ln_sum[125:64];
  end

  // Quotient c * 2^56 / ln(y), two bits per stage.
  ldiv_t dv [0:LDIV_STAGES];

  assign dv[0] = '{r: {30'b0, temp_scale}, q: '0, lnq: lnq};

  for (genvar i = 0; i < LDIV_STAGES; i++) begin : g_ldiv
    always_ff @(posedge clk) begin
      dv[i+1] <= ldiv_step(ldiv_step(dv[i]));
    end
  end

  // ---------------------------------------------------------------------------
  // Inverse square root path (mode 1): isqrt(floor(c*c / (x+1))).
  // ---------------------------------------------------------------------------
  logic [63:0] c_sq;
  logic [32:0] x_inc;
  qdiv_t       qd [0:QDIV_STAGES];
  sqrt_t       sr [0:SQRT_STAGES];
  logic [31:0] sq_dly [1:LOG_DEPTH-SQ_DEPTH];

  always_ff @(posedge clk) begin
    c_sq  <= temp_scale * temp_scale;
    x_inc <= {1'b0, x0} + 33'd1;
  end

  assign qd[0] = '{nq: c_sq, rem: '0, d: x_inc};

  for (genvar i = 0; i < QDIV_STAGES; i++) begin : g_qdiv
    always_ff @(posedge clk) begin
      qd[i+1] <= qdiv_step(qdiv_step(qd[i]));
    end
  end

  assign sr[0] = '{v: qd[QDIV_STAGES].nq, rem: '0, root: '0};

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
    always_ff @(posedge clk) begin
      sr[i+1] <= sqrt_step(sqrt_step(sr[i]));
    end
  end

  // Hold the root until the log path catches up.
  always_ff @(posedge clk) begin
    sq_dly[1] <= sr[SQRT_STAGES].root;
    for (int i = 1; i < LOG_DEPTH - SQ_DEPTH; i++) sq_dly[i+1] <= sq_dly[i];
  end

  // ---------------------------------------------------------------------------
  // Linear clamp path (mode 3): c*2^16 - slope*x in units of 2^-32.
  // ---------------------------------------------------------------------------
  logic [63:0] lin_plo;
  logic [47:0] lin_phi;
  logic [79:0] lin_prod;
  logic [79:0] lin_base;
  logic [79:0] lin_diff;
  logic [31:0] lin_res;
  logic [31:0] lin_dly [1:LOG_DEPTH-LIN_DEPTH];

  always_ff @(posedge clk) begin
    lin_plo <= slope[31:0]  * x0;
    lin_phi <= slope[47:32] * x0;
  end

  assign lin_prod = {lin_phi, 32'b0} + {16'b0, lin_plo};
  assign lin_base = {32'b0, temp_scale, 16'b0};
  assign lin_diff = lin_base - lin_prod;

  always_ff @(posedge clk) begin
    lin_res <= (lin_prod >= lin_base) ? 32'd0 : lin_diff[47:16];
  end

  always_ff @(posedge clk) begin
    lin_dly[1] <= lin_res;
    for (int i = 1; i < LOG_DEPTH - LIN_DEPTH; i++) lin_dly[i+1] <= lin_dly[i];
  end

  // ---------------------------------------------------------------------------
  // Output: select by mode, clamp to temp_scale, strobe for one cycle.
  // ---------------------------------------------------------------------------
  logic [31:0] log_res;
  logic [31:0] sq_res;
  logic [31:0] result_next;

  assign log_res = (dv[LDIV_STAGES].q > {24'b0, temp_scale}) ? temp_scale
                                                              : dv[LDIV_STAGES].q[31:0];
  assign sq_res  = (sq_dly[LOG_DEPTH-SQ_DEPTH] > temp_scale) ? temp_scale
                                                              : sq_dly[LOG_DEPTH-SQ_DEPTH];

  always_comb begin
    case (mode)
      MODE_CONST:  result_next = temp_scale;
      MODE_ISQRT:  result_next = sq_res;
      MODE_ILOG:   result_next = log_res;
      MODE_LINEAR: result_next = lin_dly[LOG_DEPTH-LIN_DEPTH];
      default:     result_next = temp_scale;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= valid_pipe[LOG_DEPTH];
    end
  end

  always_ff @(posedge clk) begin
    temperature <= result_next;
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(LOG_DEPTH + 2) done)
    else $error("accepted word did not strobe done at the fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LOG_DEPTH + 2))
    else $error("done strobed without a matching accepted word");

  a_temp_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (temperature <= temp_scale))
    else $error("temperature above temp_scale");

endmodule
